>>> src/aecp_pkg.sv
package aecp_pkg;

   // Payload of one input beat and one result beat
   typedef struct packed {
      logic [7:0] char_code;
      logic [7:0] cur_row;
      logic [7:0] cur_col;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] out_char;
      logic [7:0] attribute;
      logic [7:0] row;
      logic [7:0] col;
   } rsp_type;

   // Display actions
   localparam logic [1:0] ACT_PUT = 2'd0;
   localparam logic [1:0] ACT_POS = 2'd1;
   localparam logic [1:0] ACT_CLS = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_MAX_ROW    = 2'd0;
   localparam logic [1:0] CSR_MAX_COL    = 2'd1;
   localparam logic [1:0] CSR_COLOUR_EN  = 2'd2;

   // Register reset values
   localparam logic [7:0] MAX_ROW_RESET = 8'd24;
   localparam logic [7:0] MAX_COL_RESET = 8'd79;
   localparam logic [7:0] ATTR_RESET    = 8'h07;

   // Console bytes of interest
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_FF      = 8'h0C;
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_UP      = 8'h41;
   localparam logic [7:0] CH_DOWN    = 8'h42;
   localparam logic [7:0] CH_RIGHT   = 8'h43;
   localparam logic [7:0] CH_LEFT    = 8'h44;
   localparam logic [7:0] CH_POS     = 8'h48;
   localparam logic [7:0] CH_CLEAR   = 8'h4A;
   localparam logic [7:0] CH_SGR     = 8'h6D;

   // Attribute bits and masks
   localparam logic [7:0] ATTR_BOLD    = 8'h08;
   localparam logic [7:0] ATTR_BLINK   = 8'h80;
   localparam logic [7:0] ATTR_REVERSE = 8'h70;
   localparam logic [7:0] ATTR_FG_KEEP = 8'hF8;
   localparam logic [7:0] ATTR_BG_KEEP = 8'h8F;
   localparam logic [7:0] TAB_MASK     = 8'hF8;

   localparam logic [2:0] COLOUR_MAP [8] = '{
      3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7
   };

   // Escape parse phase
   typedef enum logic [1:0] {
      PH_TEXT  = 2'd0,
      PH_ESC   = 2'd1,
      PH_CSI   = 2'd2,
      PH_SPARE = 2'd3
   } phase_type;

   // What the latched byte asks for
   typedef enum logic [4:0] {
      CL_TAB,
      CL_FF,
      CL_ESC,
      CL_PUT,
      CL_OPEN,
      CL_SEMI,
      CL_DIGIT,
      CL_INTER,
      CL_FIN_UP,
      CL_FIN_DOWN,
      CL_FIN_RIGHT,
      CL_FIN_LEFT,
      CL_FIN_POS,
      CL_FIN_CLEAR,
      CL_FIN_SGR,
      CL_FIN_NONE,
      CL_SPARE
   } cls_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MAC10
   } alu_op_type;

   typedef enum logic [3:0] {
      OPD_ZERO,
      OPD_ROW,
      OPD_COL,
      OPD_MOVE_N,
      OPD_ARG_RD,
      OPD_ARG0,
      OPD_ARG1,
      OPD_TMP,
      OPD_MAX_ROW,
      OPD_MAX_COL,
      OPD_DIGIT,
      OPD_EIGHT,
      OPD_ONE
   } opnd_type;

   typedef enum logic [3:0] {
      RES_NONE,
      RES_PUT,
      RES_TAB,
      RES_HOME,
      RES_CLS,
      RES_UP,
      RES_LEFT,
      RES_CLAMP_ROW,
      RES_CLAMP_COL,
      RES_POS
   } res_sel_type;

   typedef enum logic [1:0] {
      ARG_NONE,
      ARG_CLEAR,
      ARG_DIGIT,
      ARG_SEMI
   } arg_op_type;

   typedef enum logic [1:0] {
      PHO_KEEP,
      PHO_ESC,
      PHO_OPEN,
      PHO_TEXT
   } phase_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CLAMP_ROW,
      ST_CLAMP_COL,
      ST_POS_COL,
      ST_SGR,
      ST_EMIT,
      ST_EMIT_HOME
   } state_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic    req_fire;
      cls_type cls;
      logic    rsp_free;
      logic    arg0_two;
      logic    sgr_done;
   } stat_type;

   // Sequencer commands to the datapath
   typedef struct packed {
      logic         ready;
      alu_op_type   alu_op;
      opnd_type     a_sel;
      opnd_type     b_sel;
      res_sel_type  res_sel;
      logic         tmp_ld;
      arg_op_type   arg_op;
      logic         inter_ld;
      phase_op_type phase_op;
      logic         walk_clr;
      logic         sgr_step;
      logic         rsp_ld;
   } ctl_type;

   // Sort a console byte by parse phase
   function automatic cls_type classify(input logic [7:0] ch, input phase_type ph,
                                        input logic inter_nz);
      cls_type c;
      c = CL_PUT;
      if (ph == PH_TEXT || ch < CH_SPACE || ch > CH_TILDE) begin
         if (ch == CH_TAB) c = CL_TAB;
         else if (ch == CH_FF) c = CL_FF;
         else if (ch == CH_ESC) c = CL_ESC;
         else c = CL_PUT;
      end else if (ph == PH_ESC) begin
         c = CL_OPEN;
      end else if (ph == PH_CSI) begin
         if (ch == CH_SEMI) c = CL_SEMI;
         else if (ch >= CH_ZERO && ch <= CH_NINE) c = CL_DIGIT;
         else if (ch >= CH_AT) begin
            if (inter_nz) c = CL_FIN_NONE;
            else if (ch == CH_UP) c = CL_FIN_UP;
            else if (ch == CH_DOWN) c = CL_FIN_DOWN;
            else if (ch == CH_RIGHT) c = CL_FIN_RIGHT;
            else if (ch == CH_LEFT) c = CL_FIN_LEFT;
            else if (ch == CH_POS) c = CL_FIN_POS;
            else if (ch == CH_CLEAR) c = CL_FIN_CLEAR;
            else if (ch == CH_SGR) c = CL_FIN_SGR;
            else c = CL_FIN_NONE;
         end else c = CL_INTER;
      end else begin
         c = CL_SPARE;
      end
      return c;
   endfunction

   // One SGR argument applied to the attribute
   function automatic logic [7:0] sgr_apply(input logic [7:0] attr, input logic [15:0] v,
                                            input logic colour_en);
      logic [15:0] fg;
      logic [15:0] bg;
      logic [7:0]  a;
      fg = v - 16'd30;
      bg = v - 16'd40;
      a  = attr;
      if (v == 16'd0) a = ATTR_RESET;
      else if (v == 16'd1) a = attr | ATTR_BOLD;
      else if (v == 16'd5) a = attr | ATTR_BLINK;
      else if (v == 16'd7) a = ATTR_REVERSE;
      else if (v >= 16'd30 && v <= 16'd37) begin
         if (colour_en) a = (attr & ATTR_FG_KEEP) | {5'd0, COLOUR_MAP[fg[2:0]]};
      end else if (v >= 16'd40 && v <= 16'd47) begin
         if (colour_en) a = (attr & ATTR_BG_KEEP) | {1'b0, COLOUR_MAP[bg[2:0]], 4'd0};
      end
      return a;
   endfunction

endpackage

>>> src/aecp_alu.sv
module aecp_alu (
   input  aecp_pkg::alu_op_type op,
   input  logic [16:0]          a,
   input  logic [16:0]          b,
   output logic [16:0]          result
);
   import aecp_pkg::*;

   // Shared adder: sum, difference with borrow in bit 16, or times ten plus digit
   always_comb begin
      unique case (op)
         ALU_ADD:   result = a + b;
         ALU_SUB:   result = a - b;
         ALU_MAC10: result = (a << 3) + (a << 1) + b;
         default:   result = a + b;
      endcase
   end

endmodule

>>> src/aecp_fsm.sv
module aecp_fsm (
   input  logic               clock,
   input  logic               reset,
   input  aecp_pkg::stat_type stat,
   output aecp_pkg::ctl_type  ctl
);
   import aecp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (stat.req_fire) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (stat.cls)
               CL_TAB, CL_PUT, CL_FIN_UP, CL_FIN_LEFT: state_in = ST_EMIT;
               CL_FF:        state_in = ST_EMIT_HOME;
               CL_FIN_DOWN:  state_in = ST_CLAMP_ROW;
               CL_FIN_RIGHT: state_in = ST_CLAMP_COL;
               CL_FIN_POS:   state_in = ST_POS_COL;
               CL_FIN_CLEAR: state_in = stat.arg0_two ? ST_EMIT : ST_IDLE;
               CL_FIN_SGR:   state_in = ST_SGR;
               default:      state_in = ST_IDLE;
            endcase
         end
         ST_CLAMP_ROW, ST_CLAMP_COL, ST_POS_COL: state_in = ST_EMIT;
         ST_SGR: begin
            if (stat.sgr_done) state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         ST_EMIT_HOME: begin
            if (stat.rsp_free) state_in = ST_EMIT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      ctl          = '0;
      ctl.alu_op   = ALU_ADD;
      ctl.a_sel    = OPD_ZERO;
      ctl.b_sel    = OPD_ZERO;
      ctl.res_sel  = RES_NONE;
      ctl.arg_op   = ARG_NONE;
      ctl.phase_op = PHO_KEEP;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.ready = 1'b1;
         end
         ST_DECODE: begin
            unique case (stat.cls)
               CL_TAB: begin
                  ctl.a_sel   = OPD_COL;
                  ctl.b_sel   = OPD_EIGHT;
                  ctl.res_sel = RES_TAB;
               end
               CL_FF:  ctl.res_sel = RES_HOME;
               CL_ESC: ctl.phase_op = PHO_ESC;
               CL_PUT: ctl.res_sel = RES_PUT;
               CL_OPEN: begin
                  ctl.arg_op   = ARG_CLEAR;
                  ctl.phase_op = PHO_OPEN;
               end
               CL_SEMI: ctl.arg_op = ARG_SEMI;
               CL_DIGIT: begin
                  ctl.alu_op = ALU_MAC10;
                  ctl.a_sel  = OPD_ARG_RD;
                  ctl.b_sel  = OPD_DIGIT;
                  ctl.arg_op = ARG_DIGIT;
               end
               CL_INTER: ctl.inter_ld = 1'b1;
               CL_FIN_UP: begin
                  ctl.phase_op = PHO_TEXT;
                  ctl.alu_op   = ALU_SUB;
                  ctl.a_sel    = OPD_ROW;
                  ctl.b_sel    = OPD_MOVE_N;
                  ctl.res_sel  = RES_UP;
               end
               CL_FIN_LEFT: begin
                  ctl.phase_op = PHO_TEXT;
                  ctl.alu_op   = ALU_SUB;
                  ctl.a_sel    = OPD_COL;
                  ctl.b_sel    = OPD_MOVE_N;
                  ctl.res_sel  = RES_LEFT;
               end
               CL_FIN_DOWN: begin
                  ctl.phase_op = PHO_TEXT;
                  ctl.a_sel    = OPD_ROW;
                  ctl.b_sel    = OPD_MOVE_N;
                  ctl.tmp_ld   = 1'b1;
               end
               CL_FIN_RIGHT: begin
                  ctl.phase_op = PHO_TEXT;
                  ctl.a_sel    = OPD_COL;
                  ctl.b_sel    = OPD_MOVE_N;
                  ctl.tmp_ld   = 1'b1;
               end
               CL_FIN_POS: begin
                  ctl.phase_op = PHO_TEXT;
                  ctl.alu_op   = ALU_SUB;
                  ctl.a_sel    = OPD_ARG0;
                  ctl.b_sel    = OPD_ONE;
                  ctl.tmp_ld   = 1'b1;
               end
               CL_FIN_CLEAR: begin
                  ctl.phase_op = PHO_TEXT;
                  if (stat.arg0_two) ctl.res_sel = RES_CLS;
               end
               CL_FIN_SGR: begin
                  ctl.phase_op = PHO_TEXT;
                  ctl.walk_clr = 1'b1;
               end
               default: ctl.phase_op = PHO_TEXT;
            endcase
         end
         ST_CLAMP_ROW: begin
            ctl.alu_op  = ALU_SUB;
            ctl.a_sel   = OPD_MAX_ROW;
            ctl.b_sel   = OPD_TMP;
            ctl.res_sel = RES_CLAMP_ROW;
         end
         ST_CLAMP_COL: begin
            ctl.alu_op  = ALU_SUB;
            ctl.a_sel   = OPD_MAX_COL;
            ctl.b_sel   = OPD_TMP;
            ctl.res_sel = RES_CLAMP_COL;
         end
         ST_POS_COL: begin
            ctl.alu_op  = ALU_SUB;
            ctl.a_sel   = OPD_ARG1;
            ctl.b_sel   = OPD_ONE;
            ctl.res_sel = RES_POS;
         end
         ST_SGR: ctl.sgr_step = 1'b1;
         ST_EMIT: ctl.rsp_ld = stat.rsp_free;
         ST_EMIT_HOME: begin
            // home goes out now, the clear follows from the result register
            ctl.rsp_ld = stat.rsp_free;
            if (stat.rsp_free) ctl.res_sel = RES_CLS;
         end
         default: ctl.ready = 1'b0;
      endcase
   end

endmodule

>>> src/ansi_escape_console_parser.sv
// Console escape parser: takes one console byte per req beat together with the cursor
// position the display reports, and returns display actions (put character, set cursor,
// clear screen) on the rsp channel, at most two per byte. The block handles one byte at a
// time and holds req_stall high until it has finished with it; a result left waiting in
// the output register does not hold up the next byte unless a further result is due.
// Plain characters, tab, clear screen and cursor up or left are resolved in the decode
// state; escape, argument, intermediate and unknown final bytes emit nothing; cursor down
// or right and absolute position pass through one more adder state, and form feed sends
// home and then clear. An SGR final byte walks the stored arguments, up to MAX_ARGUMENTS.
// A stalled rsp channel holds each result until the output register is free. The steps are
// set by the single shared adder, used once per cycle, and by the argument register walk.
// Configuration writes are always taken (csr_ready is tied high).
module ansi_escape_console_parser #(
   parameter int MAX_ARGUMENTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  aecp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output aecp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import aecp_pkg::*;

   localparam int IDX_W = $clog2(MAX_ARGUMENTS + 1);
   localparam int ADR_W = $clog2(MAX_ARGUMENTS);
   localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(MAX_ARGUMENTS);
   localparam logic [ADR_W-1:0] ADR_LAST = ADR_W'(MAX_ARGUMENTS - 1);

   stat_type stat;
   ctl_type  ctl;

   logic [7:0]       max_row_ff;
   logic [7:0]       max_col_ff;
   logic             colour_en_ff;
   req_type          in_ff;
   phase_type        phase_ff;
   phase_type        phase_in;
   logic [15:0]      arg_ff [MAX_ARGUMENTS];
   logic [IDX_W-1:0] idx_ff;
   logic [7:0]       inter_ff;
   logic [7:0]       attr_ff;
   logic [ADR_W-1:0] walk_ff;
   logic [16:0]      tmp_ff;
   rsp_type          res_ff;
   rsp_type          res_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic             req_fire;
   logic [ADR_W-1:0] rd_addr;
   logic [15:0]      arg_rd;
   logic [15:0]      move_n;
   logic [16:0]      opnd_a;
   logic [16:0]      opnd_b;
   logic [16:0]      alu_res;
   logic             borrow;
   logic             tmp_borrow;
   logic [ADR_W-1:0] walk_last;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = !ctl.ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status for the sequencer
   assign walk_last = (idx_ff == IDX_FULL) ? ADR_LAST : idx_ff[ADR_W-1:0];
   always_comb begin
      stat.req_fire = req_fire;
      stat.cls      = classify(in_ff.char_code, phase_ff, inter_ff != 8'd0);
      stat.rsp_free = !rsp_valid_ff || !rsp_stall;
      stat.arg0_two = arg_ff[0] == 16'd2;
      stat.sgr_done = walk_ff == walk_last;
   end

   aecp_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   // Single argument read port: the walk during SGR, else the current slot
   assign rd_addr = ctl.sgr_step ? walk_ff : idx_ff[ADR_W-1:0];
   assign arg_rd  = arg_ff[rd_addr];
   assign move_n  = (arg_ff[0] == 16'd0) ? 16'd1 : arg_ff[0];

   function automatic logic [16:0] pick(input opnd_type s, input logic [7:0] row,
                                        input logic [7:0] col, input logic [15:0] n,
                                        input logic [15:0] ard, input logic [15:0] a0,
                                        input logic [15:0] a1, input logic [16:0] tmp,
                                        input logic [7:0] mrow, input logic [7:0] mcol,
                                        input logic [7:0] ch);
      logic [16:0] v;
      unique case (s)
         OPD_ROW:     v = {9'd0, row};
         OPD_COL:     v = {9'd0, col};
         OPD_MOVE_N:  v = {1'b0, n};
         OPD_ARG_RD:  v = {1'b0, ard};
         OPD_ARG0:    v = {1'b0, a0};
         OPD_ARG1:    v = {1'b0, a1};
         OPD_TMP:     v = tmp;
         OPD_MAX_ROW: v = {9'd0, mrow};
         OPD_MAX_COL: v = {9'd0, mcol};
         OPD_DIGIT:   v = {13'd0, ch[3:0]};
         OPD_EIGHT:   v = 17'd8;
         OPD_ONE:     v = 17'd1;
         default:     v = 17'd0;
      endcase
      return v;
   endfunction

   // Operand selection for the shared unit
   assign opnd_a = pick(ctl.a_sel, in_ff.cur_row, in_ff.cur_col, move_n, arg_rd,
                        arg_ff[0], arg_ff[1], tmp_ff, max_row_ff, max_col_ff,
                        in_ff.char_code);
   assign opnd_b = pick(ctl.b_sel, in_ff.cur_row, in_ff.cur_col, move_n, arg_rd,
                        arg_ff[0], arg_ff[1], tmp_ff, max_row_ff, max_col_ff,
                        in_ff.char_code);

   aecp_alu u_alu (
      .op     (ctl.alu_op),
      .a      (opnd_a),
      .b      (opnd_b),
      .result (alu_res)
   );

   assign borrow     = alu_res[16];
   assign tmp_borrow = tmp_ff[16];

   // Result assembly
   always_comb begin
      res_in = res_ff;
      unique case (ctl.res_sel)
         RES_PUT:  res_in = '{ACT_PUT, in_ff.char_code, attr_ff, 8'd0, 8'd0};
         RES_TAB:  res_in = '{ACT_POS, 8'd0, 8'd0, in_ff.cur_row, alu_res[7:0] & TAB_MASK};
         RES_HOME: res_in = '{ACT_POS, 8'd0, 8'd0, 8'd0, 8'd0};
         RES_CLS:  res_in = '{ACT_CLS, 8'd0, attr_ff, 8'd0, 8'd0};
         RES_UP:   res_in = '{ACT_POS, 8'd0, 8'd0, borrow ? 8'd0 : alu_res[7:0],
                              in_ff.cur_col};
         RES_LEFT: res_in = '{ACT_POS, 8'd0, 8'd0, in_ff.cur_row,
                              borrow ? 8'd0 : alu_res[7:0]};
         RES_CLAMP_ROW: res_in = '{ACT_POS, 8'd0, 8'd0, borrow ? max_row_ff : tmp_ff[7:0],
                                   in_ff.cur_col};
         RES_CLAMP_COL: res_in = '{ACT_POS, 8'd0, 8'd0, in_ff.cur_row,
                                   borrow ? max_col_ff : tmp_ff[7:0]};
         RES_POS:  res_in = '{ACT_POS, 8'd0, 8'd0, tmp_borrow ? 8'd0 : tmp_ff[7:0],
                              borrow ? 8'd0 : alu_res[7:0]};
         default:  res_in = res_ff;
      endcase
   end

   // Next parse phase
   always_comb begin
      unique case (ctl.phase_op)
         PHO_ESC:  phase_in = PH_ESC;
         PHO_OPEN: phase_in = (in_ff.char_code == CH_BRACKET) ? PH_CSI : PH_TEXT;
         PHO_TEXT: phase_in = PH_TEXT;
         default:  phase_in = phase_ff;
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_row_ff   <= MAX_ROW_RESET;
         max_col_ff   <= MAX_COL_RESET;
         colour_en_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_ROW:   max_row_ff   <= csr_wdata;
            CSR_MAX_COL:   max_col_ff   <= csr_wdata;
            CSR_COLOUR_EN: colour_en_ff <= csr_wdata[0];
            default:       max_row_ff   <= max_row_ff;
         endcase
      end
   end

   // Latched input beat and scratch registers
   always_ff @(posedge clock) begin
      if (req_fire) in_ff <= req_data;
      if (ctl.tmp_ld) tmp_ff <= alu_res;
      res_ff <= res_in;
   end

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TEXT;
         idx_ff   <= '0;
         inter_ff <= 8'd0;
         attr_ff  <= ATTR_RESET;
         walk_ff  <= '0;
         for (int i = 0; i < MAX_ARGUMENTS; i++) arg_ff[i] <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         if (ctl.inter_ld) inter_ff <= in_ff.char_code;
         unique case (ctl.arg_op)
            ARG_CLEAR: begin
               idx_ff   <= '0;
               inter_ff <= 8'd0;
               for (int i = 0; i < MAX_ARGUMENTS; i++) arg_ff[i] <= 16'd0;
            end
            ARG_SEMI: begin
               if (idx_ff != IDX_FULL) idx_ff <= idx_ff + IDX_W'(1);
            end
            ARG_DIGIT: begin
               // digits past the last slot are dropped
               if (idx_ff != IDX_FULL) arg_ff[idx_ff[ADR_W-1:0]] <= alu_res[15:0];
            end
            default: idx_ff <= idx_ff;
         endcase
         if (ctl.walk_clr) walk_ff <= '0;
         else if (ctl.sgr_step) walk_ff <= walk_ff + ADR_W'(1);
         if (ctl.sgr_step) attr_ff <= sgr_apply(attr_ff, arg_rd, colour_en_ff);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_ld) rsp_data_ff <= res_ff;
   end

endmodule

>>> bench/ansi_escape_console_parser_test.sv
`timescale 1ns / 100ps

module ansi_escape_console_parser_test;
   import aecp_pkg::*;

   localparam int ARG_SLOTS     = 8;
   localparam int SETTLE_CYCLES = 24;   // longest byte: SGR walking every argument
   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 120;
   localparam logic [2:0] PALETTE [8] = '{
      3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7
   };

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_MAX_ROW;
   logic [7:0] csr_wdata = '0;

   // bytes waiting to be sent, display actions waiting to come back
   req_type    byte_queue[$];
   rsp_type    pending_actions[$];
   int         bytes_queued = 0;
   int         bytes_sent   = 0;
   int         actions_seen = 0;
   int         errors       = 0;

   // shadow of the parser state and its registers
   logic [7:0]  row_limit  = MAX_ROW_RESET;
   logic [7:0]  col_limit  = MAX_COL_RESET;
   logic        colour_on  = 1'b1;
   phase_type   esc_phase  = PH_TEXT;
   logic [15:0] csi_args [ARG_SLOTS];
   logic [3:0]  csi_count  = '0;
   logic [7:0]  csi_inter  = '0;
   logic [7:0]  cur_attr   = ATTR_RESET;

   ansi_escape_console_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      foreach (csi_args[i]) csi_args[i] = '0;
   end

   // ---------------------------------------------------------------
   // Console behaviour
   // ---------------------------------------------------------------

   function void expect_action(logic [1:0] act, logic [7:0] ch, logic [7:0] attr,
                               logic [7:0] row, logic [7:0] col);
      rsp_type a;
      a.action    = act;
      a.out_char  = ch;
      a.attribute = attr;
      a.row       = row;
      a.col       = col;
      pending_actions.push_back(a);
   endfunction

   // Display actions caused by one console byte
   function void console_byte(req_type r);
      logic [7:0]  ch;
      logic [7:0]  tab_col;
      int unsigned n, rr, cc, argc, v;
      ch = r.char_code;
      rr = r.cur_row;
      cc = r.cur_col;
      if (esc_phase == PH_TEXT || ch < CH_SPACE || ch > CH_TILDE) begin
         // control bytes act as plain text even mid-sequence
         if (ch == CH_TAB) begin
            tab_col = r.cur_col + 8'd8;
            expect_action(ACT_POS, 8'd0, 8'd0, r.cur_row, tab_col & TAB_MASK);
         end else if (ch == CH_FF) begin
            expect_action(ACT_POS, 8'd0, 8'd0, 8'd0, 8'd0);
            expect_action(ACT_CLS, 8'd0, cur_attr, 8'd0, 8'd0);
         end else if (ch == CH_ESC) begin
            esc_phase = PH_ESC;
         end else begin
            expect_action(ACT_PUT, ch, cur_attr, 8'd0, 8'd0);
         end
      end else if (esc_phase == PH_ESC) begin
         foreach (csi_args[i]) csi_args[i] = '0;
         csi_count = '0;
         csi_inter = '0;
         esc_phase = (ch == CH_BRACKET) ? PH_CSI : PH_TEXT;
      end else if (esc_phase == PH_CSI) begin
         if (ch == CH_SEMI) begin
            if (csi_count < ARG_SLOTS) csi_count = csi_count + 4'd1;
         end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            // digits past a saturated index are dropped
            if (csi_count < ARG_SLOTS)
               csi_args[csi_count] = csi_args[csi_count] * 16'd10 + 16'(ch - CH_ZERO);
         end else if (ch >= CH_AT) begin
            esc_phase = PH_TEXT;
            if (csi_inter == 8'd0) begin
               n = (csi_args[0] < 16'd1) ? 1 : csi_args[0];
               case (ch)
                  CH_UP: begin
                     rr = (n > rr) ? 0 : rr - n;
                     expect_action(ACT_POS, 8'd0, 8'd0, rr[7:0], cc[7:0]);
                  end
                  CH_DOWN: begin
                     rr = (n + rr > row_limit) ? row_limit : rr + n;
                     expect_action(ACT_POS, 8'd0, 8'd0, rr[7:0], cc[7:0]);
                  end
                  CH_RIGHT: begin
                     cc = (n + cc > col_limit) ? col_limit : cc + n;
                     expect_action(ACT_POS, 8'd0, 8'd0, rr[7:0], cc[7:0]);
                  end
                  CH_LEFT: begin
                     cc = (n > cc) ? 0 : cc - n;
                     expect_action(ACT_POS, 8'd0, 8'd0, rr[7:0], cc[7:0]);
                  end
                  CH_POS: begin
                     // one-based, low byte only
                     rr = (csi_args[0] >= 16'd1) ? csi_args[0] - 1 : 0;
                     cc = (csi_args[1] >= 16'd1) ? csi_args[1] - 1 : 0;
                     expect_action(ACT_POS, 8'd0, 8'd0, rr[7:0], cc[7:0]);
                  end
                  CH_CLEAR: begin
                     if (csi_args[0] == 16'd2)
                        expect_action(ACT_CLS, 8'd0, cur_attr, 8'd0, 8'd0);
                  end
                  CH_SGR: begin
                     argc = csi_count + 1;
                     if (argc > ARG_SLOTS) argc = ARG_SLOTS;
                     for (int i = 0; i < argc; i++) begin
                        v = csi_args[i];
                        if (v == 0) cur_attr = ATTR_RESET;
                        else if (v == 1) cur_attr = cur_attr | ATTR_BOLD;
                        else if (v == 5) cur_attr = cur_attr | ATTR_BLINK;
                        else if (v == 7) cur_attr = ATTR_REVERSE;
                        else if (v >= 30 && v <= 37) begin
                           if (colour_on)
                              cur_attr = (cur_attr & ATTR_FG_KEEP) | {5'd0, PALETTE[v - 30]};
                        end else if (v >= 40 && v <= 47) begin
                           if (colour_on)
                              cur_attr = (cur_attr & ATTR_BG_KEEP)
                                         | {1'b0, PALETTE[v - 40], 4'd0};
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end else begin
            csi_inter = ch;
         end
      end else begin
         esc_phase = PH_TEXT;
      end
   endfunction

   // ---------------------------------------------------------------
   // Byte sender
   // ---------------------------------------------------------------

   always @(posedge clock) begin : sender
      logic   offer;
      req_type next_byte;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            console_byte(req_data);
            bytes_sent++;
         end
         // a stalled beat holds still
         if (!req_valid || !req_stall) begin
            offer = byte_queue.size() != 0 &&
                    ((bytes_sent >= 500 && bytes_sent < 650) || $urandom_range(0, 99) >= 10);
            if (offer) begin
               next_byte = byte_queue.pop_front();
               req_data  <= next_byte;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Action receiver and checker
   // ---------------------------------------------------------------

   function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin : receiver
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            actions_seen++;
            if (pending_actions.size() == 0) begin
               $display("%0t: unexpected action, expected none, actual %h", $time, rsp_data);
               errors++;
            end else begin
               want = pending_actions.pop_front();
               compare_field("action", 8'(want.action), 8'(rsp_data.action));
               compare_field("out_char", want.out_char, rsp_data.out_char);
               compare_field("attribute", want.attribute, rsp_data.attribute);
               compare_field("row", want.row, rsp_data.row);
               compare_field("col", want.col, rsp_data.col);
            end
         end
         // one long hold-off so the parser backs up into its input
         if (!hold_done && actions_seen >= 150) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (actions_seen >= 400 && actions_seen < 550) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 10);
         end
      end
   end

   // ---------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------

   function int unsigned pick_pos();
      case ($urandom_range(0, 2))
         0:       return $urandom_range(0, 255);
         1:       return $urandom_range(0, 40);
         default: return $urandom_range(240, 255);
      endcase
   endfunction

   function void push_at(logic [7:0] ch, logic [7:0] row, logic [7:0] col);
      req_type b;
      b.char_code = ch;
      b.cur_row   = row;
      b.cur_col   = col;
      byte_queue.push_back(b);
      bytes_queued++;
   endfunction

   function void push_byte(logic [7:0] ch);
      push_at(ch, 8'(pick_pos()), 8'(pick_pos()));
   endfunction

   function void push_text(string s, logic [7:0] row, logic [7:0] col);
      for (int i = 0; i < s.len(); i++) push_at(s[i], row, col);
   endfunction

   // SGR codes, small counts and positions, and values that wrap 16 bits
   function int unsigned pick_arg();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 1;
         2:       return 2;
         3:       return 5;
         4:       return 7;
         5:       return $urandom_range(30, 37);
         6:       return $urandom_range(40, 47);
         7:       return $urandom_range(0, 299);
         8:       return $urandom_range(0, 65535);
         default: return $urandom_range(65536, 9999999);
      endcase
   endfunction

   function logic [7:0] pick_control();
      logic [7:0] c;
      c = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255));
      return c;
   endfunction

   function void push_number(int unsigned value);
      string digits;
      digits = $sformatf("%0d", value);
      for (int i = 0; i < digits.len(); i++) push_byte(digits[i]);
   endfunction

   function void push_sequence();
      int          nargs;
      logic [7:0]  finals [8];
      finals = '{CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_POS, CH_CLEAR, CH_SGR, CH_SGR};
      nargs  = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 11) : $urandom_range(0, 3);
      push_byte(CH_ESC);
      push_byte(CH_BRACKET);
      for (int i = 0; i < nargs; i++) begin
         if (i > 0) push_byte(CH_SEMI);
         if ($urandom_range(0, 4) != 0) push_number(pick_arg());
         if ($urandom_range(0, 19) == 0) push_byte(pick_control());
      end
      if ($urandom_range(0, 11) == 0)
         push_byte($urandom_range(0, 1) ? 8'($urandom_range(32, 47))
                                        : 8'($urandom_range(60, 63)));
      if ($urandom_range(0, 7) == 0) push_byte(8'($urandom_range(64, 126)));
      else push_byte(finals[$urandom_range(0, 7)]);
   endfunction

   task automatic queue_random(int count);
      int stop_at;
      stop_at = bytes_queued + count;
      while (bytes_queued < stop_at) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3:   push_byte(8'($urandom_range(0, 255)));
            4, 5, 6:      push_byte(8'($urandom_range(32, 126)));
            7:            begin push_byte(CH_ESC); push_byte(8'($urandom_range(0, 255))); end
            8:            push_byte(CH_TAB);
            9:            push_byte(CH_FF);
            default:      push_sequence();
         endcase
      end
   endtask

   // wait for every byte to go in and every action to come out
   task automatic drain();
      while (byte_queue.size() != 0 || req_valid) @(posedge clock);
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] value);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAX_ROW:   row_limit = value;
         CSR_MAX_COL:   col_limit = value;
         CSR_COLOUR_EN: colour_on = value[0];
         default: ;
      endcase
   endtask

   task automatic set_screen(logic [7:0] rows, logic [7:0] cols, logic colour);
      write_reg(CSR_MAX_ROW, rows);
      write_reg(CSR_MAX_COL, cols);
      write_reg(CSR_COLOUR_EN, {7'd0, colour});
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_screen(MAX_ROW_RESET, MAX_COL_RESET, 1'b1);
      // plain bytes at the extremes, tab wrap, form feed
      push_at(8'h41, 8'd0, 8'd0);
      push_at(8'hFF, 8'd255, 8'd255);
      push_at(CH_TAB, 8'd3, 8'd250);
      push_at(CH_FF, 8'd7, 8'd7);
      // up from the top with no count, down past the last row
      push_text("\033[A", 8'd0, 8'd5);
      push_text("\033[B", 8'd30, 8'd5);
      push_text("\033[2J", 8'd1, 8'd1);
      // escape not followed by a bracket, then a final after an intermediate
      push_text("\033X", 8'd0, 8'd0);
      push_text("\033[?m", 8'd0, 8'd0);
      push_text("\033[1;31;44m", 8'd0, 8'd0);
      push_at(8'h00, 8'd0, 8'd0);
      queue_random(220);
      drain();

      set_screen(8'd0, 8'd0, 1'b0);
      queue_random(200);
      drain();

      set_screen(8'd255, 8'd255, 1'b1);
      queue_random(200);
      drain();

      set_screen(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)),
                 1'($urandom_range(0, 1)));
      queue_random(150);
      drain();

      set_screen(MAX_ROW_RESET, MAX_COL_RESET, 1'b1);
      queue_random(150);
      drain();

      if (pending_actions.size() != 0) begin
         $display("%0t: %0d actions never arrived", $time, pending_actions.size());
         errors++;
      end
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
